// ===== hdl/qvr_pkg.sv =====
// ----------------------------------------------------------------------------
// qvr_pkg: shared definitions for the queue with value removal
// Command and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package qvr_pkg;

	// Default sizes of the value store.
	localparam int DEPTH_DEF      = 16;
	localparam int VALUE_BITS_DEF = 16;

	// Fixed widths of the command and result fields.
	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND      = 2'd0,
		CMD_REMOVE_HEAD = 2'd1,
		CMD_REMOVE_TAIL = 2'd2,
		CMD_REMOVE_VAL  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_EMPTY     = 2'd2,
		STATUS_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_SHIFT
	} state_t;

endpackage

// ===== hdl/qvr_ram.sv =====
// ----------------------------------------------------------------------------
// qvr_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module qvr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== hdl/queue_with_value_removal.sv =====
// ----------------------------------------------------------------------------
// queue_with_value_removal: linear array queue with removal by value
// Append, remove head, remove tail and remove a given value, one command
// at a time, with the entries held in a single synchronous RAM.
// ----------------------------------------------------------------------------
// A command is transferred at a rising edge where start is high and busy is
// low. Its result is presented on result_value, status and occupancy for
// exactly one cycle, marked by done; the receiver cannot stall it, so the
// result must be taken in that cycle. A new command may be transferred in
// the same cycle as done. An append, any full or empty refusal and the
// removal of a value from an empty queue end straight from idle; removing
// the head or the tail passes through the read state, as the entry is
// read through the RAM's registered port. Removing a value scans from
// the tail towards the head, one RAM read per cycle with each compare in
// the cycle after its read, and then moves each later entry one slot
// down, one read and one write per cycle. The single RAM read port sets
// this pace. Slots freed at the head are never reused, and the queue
// reports full once the tail reaches DEPTH.
// ----------------------------------------------------------------------------
module queue_with_value_removal
	import qvr_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CMD_W-1:0]    command,
	input  logic [VALUE_W-1:0]  value,
	output logic                done,
	output logic [VALUE_W-1:0]  result_value,
	output logic [STATUS_W-1:0] status,
	output logic [OCC_W-1:0]    occupancy
);

	// The RAM address covers the slots; the indices must also hold DEPTH.
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(DEPTH);

	state_t state_q, state_d;

	logic [IDX_W-1:0] head_q, tail_q;
	logic [IDX_W-1:0] scan_ptr_q;   // next slot to read while scanning
	logic [IDX_W-1:0] left_q;       // slots still to read while scanning
	logic [IDX_W-1:0] rd_ptr_q;     // next slot to read while shifting
	logic             pend_s1;      // a RAM read was issued last cycle
	logic [AW-1:0]    pend_addr_s1; // and this was its address
	cmd_t             cmd_q;
	logic [VALUE_BITS-1:0] val_q;

	logic                  done_q;
	logic [VALUE_BITS-1:0] res_value_q;
	status_t               res_status_q;

	// RAM ports
	logic                  ram_wr_en, ram_rd_en;
	logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
	logic [VALUE_BITS-1:0] ram_wr_data, ram_rd_data;

	logic                  accept;
	cmd_t                  cmd_in;
	logic [VALUE_BITS-1:0] val_in;
	logic                  is_full, is_empty;
	logic                  hit, miss, shift_end;
	logic [IDX_W-1:0]      tail_less_one;

	// Fit the input value to the stored width: truncate or zero-extend.
	always_comb begin
		for (int i = 0; i < VALUE_BITS; i++) begin
			val_in[i] = (i < VALUE_W) ? value[i] : 1'b0;
		end
	end

	always_comb begin
		for (int i = 0; i < VALUE_W; i++) begin
			result_value[i] = (i < VALUE_BITS) ? res_value_q[i] : 1'b0;
		end
	end

	assign cmd_in        = cmd_t'(command);
	assign busy          = (state_q != ST_IDLE);
	assign accept        = start && !busy;
	assign is_full       = (tail_q == DEPTH_IDX);
	assign is_empty      = (head_q == tail_q);
	assign tail_less_one = tail_q - IDX_W'(1);

	// Scan outcome: the compare runs on the data of last cycle's read.
	assign hit       = (state_q == ST_SCAN) && pend_s1 && (ram_rd_data == val_q);
	assign miss      = (state_q == ST_SCAN) && pend_s1 && (ram_rd_data != val_q)
	                   && (left_q == '0);
	// The shift ends once every later entry is read and the last write is out.
	assign shift_end = (state_q == ST_SHIFT) && !pend_s1 && (rd_ptr_q == tail_q);

	assign done      = done_q;
	assign status    = res_status_q;
	// Between head and tail after the command; the indices settle with done.
	assign occupancy = OCC_W'(tail_q - head_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_in)
						CMD_REMOVE_HEAD,
						CMD_REMOVE_TAIL: if (!is_empty) state_d = ST_READ;
						CMD_REMOVE_VAL:  if (!is_empty) state_d = ST_SCAN;
						default:         state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_SCAN: begin
				if (hit) begin
					state_d = ST_SHIFT;
				end else if (miss) begin
					state_d = ST_IDLE;
				end
			end
			ST_SHIFT: if (shift_end) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = tail_q[AW-1:0];
		ram_wr_data = val_in;
		ram_rd_en   = 1'b0;
		ram_rd_addr = head_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd_in)
						CMD_APPEND: ram_wr_en = !is_full;
						CMD_REMOVE_HEAD: ram_rd_en = !is_empty;
						CMD_REMOVE_TAIL: begin
							ram_rd_en   = !is_empty;
							ram_rd_addr = tail_less_one[AW-1:0];
						end
						default: ram_rd_en = 1'b0;
					endcase
				end
			end
			ST_SCAN: begin
				// No further read once a match is seen, so the shift starts
				// with nothing in flight.
				ram_rd_en   = (left_q != '0) && !hit;
				ram_rd_addr = scan_ptr_q[AW-1:0];
			end
			ST_SHIFT: begin
				// Read slot j while writing the data read from slot j-1 into the slot
				// below it: the two never meet.
				ram_rd_en   = (rd_ptr_q != tail_q);
				ram_rd_addr = rd_ptr_q[AW-1:0];
				ram_wr_en   = pend_s1;
				ram_wr_addr = pend_addr_s1 - AW'(1);
				ram_wr_data = ram_rd_data;
			end
			default: ram_rd_en = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= ram_rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd_in)
							CMD_APPEND: begin
								done_q <= 1'b1;
								if (!is_full) tail_q <= tail_q + IDX_W'(1);
							end
							CMD_REMOVE_HEAD,
							CMD_REMOVE_TAIL,
							CMD_REMOVE_VAL: done_q <= is_empty;
							default: done_q <= 1'b0;
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_READ: begin
					done_q <= 1'b1;
					if (cmd_q == CMD_REMOVE_HEAD) begin
						head_q <= head_q + IDX_W'(1);
					end else begin
						tail_q <= tail_less_one;
					end
				end
				ST_SCAN: done_q <= miss;
				ST_SHIFT: begin
					done_q <= shift_end;
					if (shift_end) tail_q <= tail_less_one;
				end
				default: done_q <= 1'b0;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		pend_addr_s1 <= ram_rd_addr;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q       <= cmd_in;
					val_q       <= val_in;
					scan_ptr_q  <= tail_less_one;
					left_q      <= tail_q - head_q;
					res_value_q <= '0;
					case (cmd_in)
						CMD_APPEND:     res_status_q <= is_full ? STATUS_FULL : STATUS_OK;
						CMD_REMOVE_VAL: res_status_q <= STATUS_NOT_FOUND;
						default:        res_status_q <= STATUS_EMPTY;
					endcase
				end
			end
			ST_READ: begin
				res_value_q  <= ram_rd_data;
				res_status_q <= STATUS_OK;
			end
			ST_SCAN: begin
				if (ram_rd_en) begin
					scan_ptr_q <= scan_ptr_q - IDX_W'(1);
					left_q     <= left_q - IDX_W'(1);
				end
				if (hit) begin
					res_value_q  <= ram_rd_data;
					res_status_q <= STATUS_OK;
					rd_ptr_q     <= IDX_W'(pend_addr_s1) + IDX_W'(1);
				end else begin
					res_value_q  <= '0;
					res_status_q <= STATUS_NOT_FOUND;
				end
			end
			ST_SHIFT: begin
				if (ram_rd_en) rd_ptr_q <= rd_ptr_q + IDX_W'(1);
			end
			default: cmd_q <= cmd_q;
		endcase
	end

	qvr_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_entries (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for queue_with_value_removal
// Drives append, remove head, remove tail and remove value commands through
// the start/busy handshake and checks every result against a predictor.
// ----------------------------------------------------------------------------
// The testbench has three parts. A small scoreboard class carries its own
// copy of the queue: one method takes each accepted command, works out the
// result that the block ought to give and queues it, and another compares
// each strobed result with the oldest prediction. Plain tasks drive the
// command port. A monitor hands every result to the scoreboard.
//
// The head index never moves back, and reset is applied only once. Every
// successful head removal therefore costs the queue one slot for the rest
// of the run. The random part rations head removals so that the queue keeps
// room to fill, empty and refill many times over.
// ----------------------------------------------------------------------------
module tb_top;
	import qvr_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int RESET_CYCLES = 8;
	// The slowest command is a value removal that matches at the head of a
	// full queue: a full scan, then the longest shift. Settle is well above it.
	localparam int SETTLE_CYCLES = 64;
	// A generous cap on the whole run, many times the slowest legal run.
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 270;
	// Head removals stop once the head has moved past this many slots.
	localparam int HEAD_CAP     = 12;
	localparam int REPORT_LIMIT = 10;

	// Result of one command, as the block should present it.
	typedef struct {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic [OCC_W-1:0]   occupancy;
	} queue_result_t;

	// ------------------------------------------------------------------------
	// Scoreboard: a predictor of the queue and the store of due results.
	// ------------------------------------------------------------------------
	class queue_scoreboard;
		logic [VALUE_W-1:0] slots [DEPTH_DEF];
		int unsigned        head_idx;
		int unsigned        tail_idx;
		queue_result_t      due_results [$];
		int                 mismatches;
		int                 results_checked;
		int                 cmd_count [4];
		int                 status_count [4];

		function new();
			head_idx        = 0;
			tail_idx        = 0;
			mismatches      = 0;
			results_checked = 0;
			foreach (cmd_count[i]) cmd_count[i] = 0;
			foreach (status_count[i]) status_count[i] = 0;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Take one accepted command, update the copy of the queue and queue
		// the result that it must produce.
		function void note_command(cmd_t cmd, logic [VALUE_W-1:0] val);
			queue_result_t res;
			int unsigned   idx;
			int unsigned   pos;
			bit            found;

			res.value  = '0;
			res.status = STATUS_OK;
			found      = 1'b0;
			pos        = 0;
			case (cmd)
				CMD_APPEND: begin
					// Freed head slots are never reused, so full means the
					// tail has reached the end of the array.
					if (tail_idx >= DEPTH_DEF) begin
						res.status = STATUS_FULL;
					end else begin
						slots[tail_idx] = val;
						tail_idx++;
					end
				end
				CMD_REMOVE_HEAD: begin
					if (head_idx >= tail_idx) begin
						res.status = STATUS_EMPTY;
					end else begin
						res.value = slots[head_idx];
						head_idx++;
					end
				end
				CMD_REMOVE_TAIL: begin
					if (head_idx >= tail_idx) begin
						res.status = STATUS_EMPTY;
					end else begin
						tail_idx--;
						res.value = slots[tail_idx];
					end
				end
				default: begin
					// Search from the tail, so that of several copies the
					// one nearest the tail goes.
					idx = tail_idx;
					while (idx > head_idx && !found) begin
						idx--;
						if (slots[idx] == val) begin
							found = 1'b1;
							pos   = idx;
						end
					end
					if (!found) begin
						res.status = STATUS_NOT_FOUND;
					end else begin
						res.value = slots[pos];
						// Entries behind the match close the gap.
						for (idx = pos; idx + 1 < tail_idx; idx++)
							slots[idx] = slots[idx + 1];
						tail_idx--;
					end
				end
			endcase
			res.occupancy = OCC_W'(tail_idx - head_idx);
			cmd_count[cmd]++;
			status_count[res.status]++;
			due_results.push_back(res);
		endfunction

		// Compare one strobed result with the oldest prediction.
		function void check_result(logic [VALUE_W-1:0] val, logic [STATUS_W-1:0] st,
				logic [OCC_W-1:0] occ);
			queue_result_t want;

			results_checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("ERROR: unexpected result: value %h status %0d occ %0d",
						val, st, occ);
			end else begin
				want = due_results.pop_front();
				if (val !== want.value || st !== want.status || occ !== want.occupancy) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("ERROR: result %0d: expected value %h status %0d occ %0d,",
							results_checked, want.value, want.status, want.occupancy);
						$display("       got value %h status %0d occ %0d",
							val, st, occ);
					end
				end
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Block and its inputs. Every input has a known value from time zero.
	// ------------------------------------------------------------------------
	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic [CMD_W-1:0]   command  = CMD_APPEND;
	logic [VALUE_W-1:0] value    = '0;
	logic               busy;
	logic               done;
	logic [VALUE_W-1:0] result_value;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]   occupancy;

	queue_scoreboard sb;
	int              cycle_count = 0;
	int              random_sent = 0;

	queue_with_value_removal dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.value        (value),
		.done         (done),
		.result_value (result_value),
		.status       (status),
		.occupancy    (occupancy)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Results cannot be held off, so every strobe is taken at the edge that
	// ends its cycle. Outputs are read before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result_value, status, occupancy);
	end

	// Watchdog: a run that hangs or loses a result ends here as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results still due",
				cycle_count, sb.pending());
			$display("Mismatches found");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks.
	// ------------------------------------------------------------------------

	// Present one command and hold it until a transfer takes place, that is
	// an edge with start high and busy low. After the transfer the sender
	// may go idle for a while; idle_pct is the chance of an idle cycle.
	task automatic send_command(input cmd_t cmd, input logic [VALUE_W-1:0] val,
			input int idle_pct);
		start   <= 1'b1;
		command <= cmd;
		value   <= val;
		do @(posedge clk); while (busy);
		sb.note_command(cmd, val);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
	endtask

	// Stop sending until every due result has come back. At least one edge
	// passes after start falls, so start is never lowered and raised in the
	// same step.
	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() > 0);
	endtask

	// One phase of random traffic. A negative idle_pct draws a fresh idle
	// rate for each command.
	task automatic run_random(input int n_items, input int idle_pct);
		cmd_t               cmd;
		logic [VALUE_W-1:0] val;
		int                 append_pct;
		int                 pick;
		int                 gap_pct;
		int                 head_budget;

		for (int k = 0; k < n_items; k++) begin
			// Alternate between filling and draining stretches, so that the
			// queue swings between empty and full many times.
			append_pct  = ((k / 40) % 2 == 0) ? 70 : 30;
			head_budget = 2 + random_sent / 100;
			if (head_budget > HEAD_CAP)
				head_budget = HEAD_CAP;
			val  = VALUE_W'($urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < append_pct) begin
				cmd = CMD_APPEND;
				// Half the appends draw from a small set so that duplicates
				// are common for value removals.
				if ($urandom_range(0, 1) == 0)
					val = VALUE_W'($urandom_range(0, 3) * 16'h1111);
			end else if (pick < 8) begin
				cmd = CMD_REMOVE_HEAD;
				// A head removal on a non-empty queue permanently loses a
				// slot, so it is only allowed while within the ration.
				if (sb.tail_idx > sb.head_idx && sb.head_idx >= head_budget)
					cmd = CMD_REMOVE_TAIL;
			end else if (pick < 45) begin
				cmd = CMD_REMOVE_TAIL;
			end else begin
				cmd = CMD_REMOVE_VAL;
				// Mostly ask for a value that is present somewhere in the
				// queue, now and then for one picked at random.
				if (sb.tail_idx > sb.head_idx && $urandom_range(0, 99) < 85)
					val = sb.slots[$urandom_range(sb.head_idx, sb.tail_idx - 1)];
			end
			gap_pct = (idle_pct < 0) ? $urandom_range(0, 75) : idle_pct;
			send_command(cmd, val, gap_pct);
			random_sent++;
			// Once in a while the sender waits for the queue of due results
			// to run dry before it goes on.
			if ($urandom_range(0, 99) == 0)
				wait_drained();
		end
	endtask

	// Values for filling the queue in the directed part: the extremes, a
	// duplicate and walking bits.
	logic [VALUE_W-1:0] fill_values [15] = '{
		16'h0000, 16'hFFFF, 16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h0001, 16'h8000,
		16'h7FFF, 16'h0002, 16'h0004, 16'h0010, 16'h0100, 16'h1000, 16'h3C3C,
		16'hC3C3
	};

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Every removal on an empty queue first: head, tail
		// and value.
		send_command(CMD_REMOVE_HEAD, 16'h0000, 0);
		send_command(CMD_REMOVE_TAIL, 16'hFFFF, 0);
		send_command(CMD_REMOVE_VAL, 16'h1234, 0);
		// Empty again after a removal, with the indices left away from zero.
		send_command(CMD_APPEND, 16'hFFFF, 0);
		send_command(CMD_REMOVE_HEAD, 16'h0000, 0);
		send_command(CMD_REMOVE_TAIL, 16'h0000, 0);
		send_command(CMD_REMOVE_VAL, 16'hFFFF, 0);
		// Fill up to the last slot, then append once more into a full queue
		// that still has a free slot at the head.
		foreach (fill_values[i])
			send_command(CMD_APPEND, fill_values[i], 0);
		send_command(CMD_APPEND, 16'h5555, 0);
		// Of the two copies, the one nearer the tail must go.
		send_command(CMD_REMOVE_VAL, 16'hA5A5, 0);
		// A miss on a queue that is not empty.
		send_command(CMD_REMOVE_VAL, 16'h1234, 0);
		// A match at the head: the longest shift.
		send_command(CMD_REMOVE_VAL, 16'h0000, 0);
		send_command(CMD_REMOVE_TAIL, 16'h0000, 0);
		send_command(CMD_REMOVE_HEAD, 16'h0000, 0);
		wait_drained();

		// Random part in phases: back to back, a sender that idles at a 75 percent
		// chance, a sender idle now and then, and a mix of rates. The sender
		// waits for every result between phases.
		run_random(PHASE_ITEMS, 0);
		wait_drained();
		run_random(PHASE_ITEMS, 75);
		wait_drained();
		run_random(PHASE_ITEMS, 6);
		wait_drained();
		run_random(PHASE_ITEMS, -1);
		wait_drained();

		// Let any stray strobe show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d commands: %0d appends, %0d head removals,",
			sb.cmd_count[CMD_APPEND] + sb.cmd_count[CMD_REMOVE_HEAD]
				+ sb.cmd_count[CMD_REMOVE_TAIL] + sb.cmd_count[CMD_REMOVE_VAL],
			sb.cmd_count[CMD_APPEND], sb.cmd_count[CMD_REMOVE_HEAD]);
		$display("  %0d tail removals, %0d value removals",
			sb.cmd_count[CMD_REMOVE_TAIL], sb.cmd_count[CMD_REMOVE_VAL]);
		$display("Outcomes: %0d ok, %0d full, %0d empty, %0d not found;",
			sb.status_count[STATUS_OK], sb.status_count[STATUS_FULL],
			sb.status_count[STATUS_EMPTY], sb.status_count[STATUS_NOT_FOUND]);
		$display("  %0d results checked, %0d mismatches",
			sb.results_checked, sb.mismatches);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
